/* sv/imu_frame_crc16_decoder_macros.svh */
// ----------------------------------------------------------------------------
// IMU frame decoder assertion macros
// Clocked implication checks with reset disable, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_CRC16_DECODER_MACROS_SVH
`define IMU_FRAME_CRC16_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IFCD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define IFCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ifcd_pkg.sv */
// ----------------------------------------------------------------------------
// IMU frame decoder package
// Sizes, status codes, register map, FSM type and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package ifcd_pkg;

  localparam int MAX_PAYLOAD_BYTES = 256;
  localparam int RECORD_BYTES      = 76;
  localparam int WORDS             = RECORD_BYTES / 4;
  localparam int WADDR_W           = $clog2(WORDS);
  localparam int CNT_W             = $clog2(MAX_PAYLOAD_BYTES + 1);

  localparam logic [2:0] HDR_LAST = 3'd5;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_SHORT = 3'd1;
  localparam logic [2:0] STS_BAD   = 3'd2;
  localparam logic [2:0] STS_TRUNC = 3'd3;
  localparam logic [2:0] STS_CRC   = 3'd4;

  // register index, decoded from paddr[3:2]
  localparam logic [1:0] REG_SYNC0 = 2'd0;
  localparam logic [1:0] REG_SYNC1 = 2'd1;
  localparam logic [1:0] REG_TAG   = 2'd2;
  localparam logic [1:0] REG_CHK   = 2'd3;

  localparam logic [3:0] ADDR_SYNC0 = {REG_SYNC0, 2'b00};
  localparam logic [3:0] ADDR_SYNC1 = {REG_SYNC1, 2'b00};
  localparam logic [3:0] ADDR_TAG   = {REG_TAG, 2'b00};
  localparam logic [3:0] ADDR_CHK   = {REG_CHK, 2'b00};

  localparam logic [7:0] RST_SYNC0 = 8'h5A;
  localparam logic [7:0] RST_SYNC1 = 8'hA5;
  localparam logic [7:0] RST_TAG   = 8'h91;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_LOAD
  } state_e;

  // CRC-16/XMODEM, MSB first, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/ifcd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ifcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 19
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/imu_frame_crc16_decoder.sv */
// ----------------------------------------------------------------------------
// IMU frame CRC-16 decoder
// Parses sync/length/CRC framed records byte by byte, checks CRC-16/XMODEM
// and emits the 76-byte sample record as 19 words, or a single status.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  in       | in_valid_i / in_stall_o  | data_byte_i, end_of_buffer_i
//  out      | out_valid_o / out_stall_i| status_o, word_index_o,
//           |                          | word_value_o, last_o
//  cfg      | APB psel/penable/pready  | paddr, pwdata, prdata
//
//  One byte per cycle through header and payload while the input is not
//  stalled; a status appears in the cycle after its byte. A good frame drains
//  the record RAM word by word (one RAM read then one output load per word), input held.
//  Input stalls while a result waits in the output register under stall.
//  Reset clears control and config; the record RAM needs no clearing.
// ----------------------------------------------------------------------------
`include "imu_frame_crc16_decoder_macros.svh"

module imu_frame_crc16_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [4:0]  word_index_o,
  output logic [31:0] word_value_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = ifcd_pkg::CNT_W;
  localparam int AW = ifcd_pkg::WADDR_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(ifcd_pkg::WORDS - 1);

  // configuration
  logic [7:0] sync0_q, sync1_q, tag_q;
  logic       chk_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync0_q <= ifcd_pkg::RST_SYNC0;
      sync1_q <= ifcd_pkg::RST_SYNC1;
      tag_q   <= ifcd_pkg::RST_TAG;
      chk_q   <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[3:2] == ifcd_pkg::REG_SYNC0) sync0_q <= pwdata[7:0];
      if (paddr[3:2] == ifcd_pkg::REG_SYNC1) sync1_q <= pwdata[7:0];
      if (paddr[3:2] == ifcd_pkg::REG_TAG)   tag_q   <= pwdata[7:0];
      if (paddr[3:2] == ifcd_pkg::REG_CHK)   chk_q   <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3:2] == ifcd_pkg::REG_SYNC0) prdata = {24'd0, sync0_q};
    if (paddr[3:2] == ifcd_pkg::REG_SYNC1) prdata = {24'd0, sync1_q};
    if (paddr[3:2] == ifcd_pkg::REG_TAG)   prdata = {24'd0, tag_q};
    if (paddr[3:2] == ifcd_pkg::REG_CHK)   prdata = {31'd0, chk_q};
  end

  // frame state
  ifcd_pkg::state_e state_q, state_d;
  logic [2:0]    pos_q, pos_d;
  logic          inpay_q, inpay_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [15:0]   len_q, len_d;
  logic [15:0]   crc_q, crc_d, crc_new;
  logic [15:0]   rcrc_q, rcrc_d;
  logic          sbad_q, sbad_d;
  logic          skip_q, skip_d;
  logic [7:0]    first_q, first_d, first_now;
  logic [23:0]   asm_q, asm_d;
  logic [AW-1:0] idx_q, idx_d;

  logic          acc, out_free, clear;
  logic          res_valid, go_emit, word_load, rd_en, we;
  logic [2:0]    res_status;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data, rd_data;

  assign acc      = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign cnt_inc  = cnt_q + 1'b1;
  assign crc_new  = ifcd_pkg::crc16_step((pos_q == 3'd0 && !inpay_q) ? 16'd0 : crc_q,
                                         data_byte_i);
  assign first_now = (cnt_q == '0) ? data_byte_i : first_q;
  assign wr_addr   = AW'(cnt_q >> 2);
  assign wr_data   = {data_byte_i, asm_q};

  always_comb begin
    pos_d      = pos_q;
    inpay_d    = inpay_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    crc_d      = crc_q;
    rcrc_d     = rcrc_q;
    sbad_d     = sbad_q;
    skip_d     = skip_q;
    first_d    = first_q;
    asm_d      = asm_q;
    res_valid  = 1'b0;
    res_status = ifcd_pkg::STS_OK;
    go_emit    = 1'b0;
    clear      = 1'b0;
    we         = 1'b0;
    if (acc) begin
      if (skip_q) begin
        if (end_of_buffer_i) begin
          skip_d = 1'b0;
          clear  = 1'b1;
        end
      end else if (!inpay_q) begin
        unique case (pos_q)
          3'd0: begin
            sbad_d = (data_byte_i != sync0_q);
            crc_d  = crc_new;
          end
          3'd1: begin
            sbad_d = sbad_q || (data_byte_i != sync1_q);
            crc_d  = crc_new;
          end
          3'd2: begin
            len_d = {8'd0, data_byte_i};
            crc_d = crc_new;
          end
          3'd3: begin
            len_d = {data_byte_i, len_q[7:0]};
            crc_d = crc_new;
          end
          3'd4: rcrc_d = {8'd0, data_byte_i};
          default: rcrc_d = {data_byte_i, rcrc_q[7:0]};
        endcase
        if (pos_q < ifcd_pkg::HDR_LAST) begin
          pos_d = pos_q + 3'd1;
          if (end_of_buffer_i) begin
            res_valid  = 1'b1;
            res_status = ifcd_pkg::STS_SHORT;
            clear      = 1'b1;
          end
        end else if (sbad_q || len_q == 16'd0 ||
                     len_q > 16'(ifcd_pkg::MAX_PAYLOAD_BYTES)) begin
          res_valid  = 1'b1;
          res_status = ifcd_pkg::STS_BAD;
          clear      = 1'b1;
          skip_d     = !end_of_buffer_i;
        end else begin
          inpay_d = 1'b1;
          cnt_d   = '0;
          if (end_of_buffer_i) begin
            res_valid  = 1'b1;
            res_status = ifcd_pkg::STS_TRUNC;
            clear      = 1'b1;
          end
        end
      end else begin
        crc_d   = crc_new;
        cnt_d   = cnt_inc;
        first_d = first_now;
        asm_d   = {data_byte_i, asm_q[23:8]};
        // a full little-endian word lands on every fourth record byte
        we      = (cnt_q < CW'(ifcd_pkg::RECORD_BYTES)) && (cnt_q[1:0] == 2'd3);
        if (16'(cnt_inc) != len_q) begin
          if (end_of_buffer_i) begin
            res_valid  = 1'b1;
            res_status = ifcd_pkg::STS_TRUNC;
            clear      = 1'b1;
          end
        end else if (chk_q && crc_new != rcrc_q) begin
          res_valid  = 1'b1;
          res_status = ifcd_pkg::STS_CRC;
          clear      = 1'b1;
          skip_d     = !end_of_buffer_i;
        end else if (len_q < 16'(ifcd_pkg::RECORD_BYTES) || first_now != tag_q) begin
          res_valid  = 1'b1;
          res_status = ifcd_pkg::STS_BAD;
          clear      = 1'b1;
          skip_d     = !end_of_buffer_i;
        end else begin
          go_emit = 1'b1;
          clear   = 1'b1;
          skip_d  = !end_of_buffer_i;
        end
      end
    end
    if (clear) begin
      pos_d   = '0;
      inpay_d = 1'b0;
      cnt_d   = '0;
      len_d   = '0;
      crc_d   = '0;
      rcrc_d  = '0;
      sbad_d  = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ifcd_pkg::ST_RUN:  if (go_emit) state_d = ifcd_pkg::ST_READ;
      ifcd_pkg::ST_READ: state_d = ifcd_pkg::ST_LOAD;
      ifcd_pkg::ST_LOAD: begin
        if (out_free) begin
          state_d = (idx_q == LAST_IDX) ? ifcd_pkg::ST_RUN : ifcd_pkg::ST_READ;
        end
      end
      default: state_d = ifcd_pkg::ST_RUN;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    word_load  = 1'b0;
    unique case (state_q)
      ifcd_pkg::ST_RUN:  in_stall_o = out_valid_o && out_stall_i;
      ifcd_pkg::ST_READ: rd_en = 1'b1;
      ifcd_pkg::ST_LOAD: word_load = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (go_emit) begin
      idx_d = '0;
    end else if (word_load) begin
      idx_d = idx_q + 1'b1;
    end
  end

  ifcd_ram #(
    .WIDTH(32),
    .DEPTH(ifcd_pkg::WORDS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ifcd_pkg::ST_RUN;
      pos_q   <= '0;
      inpay_q <= 1'b0;
      cnt_q   <= '0;
      len_q   <= '0;
      crc_q   <= '0;
      rcrc_q  <= '0;
      sbad_q  <= 1'b0;
      skip_q  <= 1'b0;
      idx_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      inpay_q <= inpay_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
      sbad_q  <= sbad_d;
      skip_q  <= skip_d;
      idx_q   <= idx_d;
      if (res_valid || word_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    asm_q   <= asm_d;
    if (res_valid) begin
      status_o     <= res_status;
      word_index_o <= '0;
      word_value_o <= '0;
      last_o       <= 1'b1;
    end else if (word_load) begin
      status_o     <= ifcd_pkg::STS_OK;
      word_index_o <= 5'(idx_q);
      word_value_o <= rd_data;
      last_o       <= (idx_q == LAST_IDX);
    end
  end

  `IFCD_ASSERT_NOW(a_no_accept_over_held, clk_i, rst_ni, acc, !(out_valid_o && out_stall_i), "byte accepted while result held")
  `IFCD_ASSERT_NOW(a_no_write_in_emit, clk_i, rst_ni, we, state_q == ifcd_pkg::ST_RUN, "record write during emission")
  `IFCD_ASSERT_NXT(a_read_then_load, clk_i, rst_ni, state_q == ifcd_pkg::ST_READ, state_q == ifcd_pkg::ST_LOAD, "read not followed by load")
  `IFCD_ASSERT_NXT(a_last_word, clk_i, rst_ni, word_load && idx_q == LAST_IDX, out_valid_o && last_o, "final word not marked last")

endmodule

/* test/ifcd_frame_checker.sv */
// ----------------------------------------------------------------------------
// IMU frame decoder checker
// Watches the byte, result and APB channels, decodes every accepted byte with
// its own copy of the frame parser and compares each accepted result, field
// by field, with the oldest outstanding expectation. APB reads are compared
// against the shadow registers.
// ----------------------------------------------------------------------------
module ifcd_frame_checker
  import ifcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [4:0]  word_index_i,
  input  logic [31:0] word_value_i,
  input  logic        last_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  output int          mismatches_o,
  output int          results_due_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  word_index;
    logic [31:0] word_value;
    logic        last;
  } decode_result_t;

  decode_result_t expected_results_q [$];

  // shadow registers
  logic [7:0] sync0_q, sync1_q, tag_q;
  logic       check_crc_q;

  // parser state
  logic [15:0] byte_pos, frame_len, crc_acc, crc_rx;
  logic        hdr_bad, skip_to_eob, in_body;
  logic [7:0]  record_mem [RECORD_BYTES];

  function automatic logic [15:0] xmodem_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [31:0] shadow_value(input logic [3:0] addr);
    case (addr)
      ADDR_SYNC0: return {24'h0, sync0_q};
      ADDR_SYNC1: return {24'h0, sync1_q};
      ADDR_TAG:   return {24'h0, tag_q};
      ADDR_CHK:   return {31'h0, check_crc_q};
      default:    return 32'h0;
    endcase
  endfunction

  task automatic drop_frame();
    byte_pos  = '0;
    frame_len = '0;
    crc_acc   = '0;
    crc_rx    = '0;
    hdr_bad   = 1'b0;
    in_body   = 1'b0;
  endtask

  task automatic post_status(input logic [2:0] code, input logic eob);
    decode_result_t r;
    r.status     = code;
    r.word_index = '0;
    r.word_value = '0;
    r.last       = 1'b1;
    expected_results_q.push_back(r);
    drop_frame();
    skip_to_eob = !eob;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eob);
    decode_result_t r;
    logic [15:0]    pos;
    if (skip_to_eob) begin
      if (eob) begin
        skip_to_eob = 1'b0;
        drop_frame();
      end
    end else if (!in_body) begin
      pos = byte_pos;
      case (pos)
        16'd0: begin
          hdr_bad = (b != sync0_q);
          crc_acc = xmodem_step(16'h0000, b);
        end
        16'd1: begin
          if (b != sync1_q) hdr_bad = 1'b1;
          crc_acc = xmodem_step(crc_acc, b);
        end
        16'd2: begin
          frame_len = {8'h00, b};
          crc_acc   = xmodem_step(crc_acc, b);
        end
        16'd3: begin
          frame_len[15:8] = b;
          crc_acc         = xmodem_step(crc_acc, b);
        end
        16'd4: crc_rx = {8'h00, b};
        default: crc_rx[15:8] = b;
      endcase
      if (pos < 16'(HDR_LAST)) begin
        byte_pos = pos + 16'd1;
        if (eob) post_status(STS_SHORT, 1'b1);
      end else if (hdr_bad || frame_len == 16'd0 || int'(frame_len) > MAX_PAYLOAD_BYTES) begin
        post_status(STS_BAD, eob);
      end else begin
        in_body  = 1'b1;
        byte_pos = '0;
        if (eob) post_status(STS_TRUNC, 1'b1);
      end
    end else begin
      if (int'(byte_pos) < RECORD_BYTES) record_mem[byte_pos] = b;
      crc_acc  = xmodem_step(crc_acc, b);
      byte_pos = byte_pos + 16'd1;
      if (byte_pos != frame_len) begin
        if (eob) post_status(STS_TRUNC, 1'b1);
      end else if (check_crc_q && crc_acc != crc_rx) begin
        post_status(STS_CRC, eob);
      end else if (int'(frame_len) < RECORD_BYTES || record_mem[0] != tag_q) begin
        post_status(STS_BAD, eob);
      end else begin
        for (int i = 0; i < WORDS; i++) begin
          r.status     = STS_OK;
          r.word_index = 5'(i);
          r.word_value = {record_mem[4*i+3], record_mem[4*i+2],
                          record_mem[4*i+1], record_mem[4*i]};
          r.last       = (i == WORDS - 1);
          expected_results_q.push_back(r);
        end
        drop_frame();
        skip_to_eob = !eob;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decode_result_t want;
    if (!rst_ni) begin
      sync0_q      = RST_SYNC0;
      sync1_q      = RST_SYNC1;
      tag_q        = RST_TAG;
      check_crc_q  = 1'b1;
      skip_to_eob  = 1'b0;
      drop_frame();
      expected_results_q.delete();
      mismatches_o  = 0;
      results_due_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          $error("unexpected result: status %0d word_index %0d word_value %h last %0d",
                 status_i, word_index_i, word_value_i, last_i);
          mismatches_o++;
        end else begin
          want = expected_results_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatches_o++;
          end
          if (word_index_i !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, word_index_i);
            mismatches_o++;
          end
          if (word_value_i !== want.word_value) begin
            $error("word_value: expected %h, got %h", want.word_value, word_value_i);
            mismatches_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            mismatches_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) decode_byte(data_byte_i, end_of_buffer_i);

      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i)
            ADDR_SYNC0: sync0_q     = pwdata_i[7:0];
            ADDR_SYNC1: sync1_q     = pwdata_i[7:0];
            ADDR_TAG:   tag_q       = pwdata_i[7:0];
            ADDR_CHK:   check_crc_q = pwdata_i[0];
            default: ;
          endcase
        end else if (prdata_i !== shadow_value(paddr_i)) begin
          $error("prdata: expected %h, got %h", shadow_value(paddr_i), prdata_i);
          mismatches_o++;
        end
      end

      results_due_o = expected_results_q.size();
    end
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// IMU frame decoder testbench
// Feeds framed byte buffers (good records, CRC and tag errors, bad headers,
// truncations, short buffers, noise) under random request gaps and result
// stalls, reprograms the registers between phases and lets the checker
// predict and compare every result.
// ----------------------------------------------------------------------------
module testbench;
  import ifcd_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 200;
  localparam int DRAIN_WAIT  = 60;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_TAG,
    FR_TRUNC,
    FR_BAD_SYNC,
    FR_BAD_LEN,
    FR_SHORT_LEN,
    FR_NOISE
  } frame_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        end_of_buffer_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [4:0]  word_index_o;
  logic [31:0] word_value_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int results_due;
  int cycles = 0;
  int bytes_sent = 0;
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;

  // register values as last programmed, used to build frames
  logic [7:0] cfg_sync0, cfg_sync1, cfg_tag;
  logic [7:0] frame_bytes [$];

  imu_frame_crc16_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .word_index_o    (word_index_o),
    .word_value_o    (word_value_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  ifcd_frame_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .word_index_i    (word_index_o),
    .word_value_i    (word_value_o),
    .last_i          (last_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .mismatches_o    (mismatches),
    .results_due_o   (results_due)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] frame_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    return c;
  endfunction

  function automatic logic [7:0] pick_cfg_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // record-sized payloads, at most 12 bytes over
  function automatic int pick_len();
    return $urandom_range(RECORD_BYTES, RECORD_BYTES + 12);
  endfunction

  function automatic frame_kind_e pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return FR_GOOD;
    if (roll < 60) return FR_BAD_CRC;
    if (roll < 65) return FR_BAD_TAG;
    if (roll < 73) return FR_TRUNC;
    if (roll < 79) return FR_BAD_SYNC;
    if (roll < 85) return FR_BAD_LEN;
    if (roll < 92) return FR_SHORT_LEN;
    return FR_NOISE;
  endfunction

  // one byte request; valid stays up across back-to-back bytes
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_byte_i     = b;
    end_of_buffer_i = eob;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    wait (results_due == 0);
    @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] s0, input logic [7:0] s1,
                            input logic [7:0] tag, input logic chk);
    settle();
    apb_access(1'b1, ADDR_SYNC0, {24'h0, s0});
    apb_access(1'b1, ADDR_SYNC1, {24'h0, s1});
    apb_access(1'b1, ADDR_TAG, {24'h0, tag});
    apb_access(1'b1, ADDR_CHK, {31'h0, chk});
    cfg_sync0 = s0;
    cfg_sync1 = s1;
    cfg_tag   = tag;
    apb_access(1'b0, ADDR_SYNC0, 32'h0);
    apb_access(1'b0, ADDR_SYNC1, 32'h0);
    apb_access(1'b0, ADDR_TAG, 32'h0);
    apb_access(1'b0, ADDR_CHK, 32'h0);
  endtask

  // bad_sync bit 0 / bit 1 corrupt the first / second sync byte;
  // cut > 0 keeps only the first cut bytes; trailer bytes follow the frame
  task automatic run_frame(input int len, input logic [1:0] bad_sync, input logic tag_ok,
                           input logic crc_ok, input int trailer, input int cut);
    logic [7:0]  body [$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          n;
    n = (len == 0 || len > MAX_PAYLOAD_BYTES) ? 0 : len;
    frame_bytes = {};
    frame_bytes.push_back(bad_sync[0] ? cfg_sync0 ^ 8'($urandom_range(1, 255)) : cfg_sync0);
    frame_bytes.push_back(bad_sync[1] ? cfg_sync1 ^ 8'($urandom_range(1, 255)) : cfg_sync1);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    crc = 16'h0000;
    foreach (frame_bytes[i]) crc = frame_crc_step(crc, frame_bytes[i]);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (i == 0) b = tag_ok ? cfg_tag : cfg_tag ^ 8'($urandom_range(1, 255));
      body.push_back(b);
      crc = frame_crc_step(crc, b);
    end
    if (!crc_ok) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    foreach (body[i]) frame_bytes.push_back(body[i]);
    if (cut > 0) begin
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    repeat (trailer) frame_bytes.push_back(8'($urandom));
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // result side: random stall before each result, with stall-free stretches
  initial begin
    int stall_len;
    out_stall_i = 1'b1;
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 40) == 0) out_burst = ~out_burst;
      stall_len   = out_burst ? 0 : $urandom_range(0, 12);
      out_stall_i = (stall_len > 0);
      if (stall_len > 0) begin
        repeat (stall_len) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    frame_kind_e kind;
    int          len;
    int          n;
    int          frame_no;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_buffer_i = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cfg_sync0       = RST_SYNC0;
    cfg_sync1       = RST_SYNC1;
    cfg_tag         = RST_TAG;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values of the registers
    apb_access(1'b0, ADDR_SYNC0, 32'h0);
    apb_access(1'b0, ADDR_SYNC1, 32'h0);
    apb_access(1'b0, ADDR_TAG, 32'h0);
    apb_access(1'b0, ADDR_CHK, 32'h0);

    // directed: short buffers, header errors, truncations, frame-end errors
    send_byte(8'($urandom), 1'b1);
    run_frame(RECORD_BYTES, 2'b00, 1'b1, 1'b1, 0, 5);
    run_frame(RECORD_BYTES, 2'b00, 1'b1, 1'b1, 0, 6);
    run_frame(0, 2'b00, 1'b1, 1'b1, 3, 0);
    run_frame(MAX_PAYLOAD_BYTES + 1, 2'b00, 1'b1, 1'b1, 0, 0);
    // largest length passes the header, then the buffer ends early
    run_frame(MAX_PAYLOAD_BYTES, 2'b00, 1'b1, 1'b1, 0, 10);
    run_frame(RECORD_BYTES, 2'b10, 1'b1, 1'b1, 2, 6);
    run_frame(1, 2'b00, 1'b1, 1'b1, 1, 0);
    run_frame(1, 2'b00, 1'b1, 1'b0, 0, 0);
    run_frame(RECORD_BYTES, 2'b00, 1'b1, 1'b1, 0, 0);

    // extreme register settings, CRC check off then on
    set_config(8'h00, 8'hFF, 8'h00, 1'b0);
    run_frame(3, 2'b00, 1'b1, 1'b0, 0, 0);
    set_config(8'hFF, 8'h00, 8'hFF, 1'b1);

    // random frames
    frame_no = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (frame_no % 3 == 2) begin
        set_config(pick_cfg_byte(), pick_cfg_byte(), pick_cfg_byte(), 1'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        // hold off until the decoder has drained
        in_valid_i = 1'b0;
        wait (results_due == 0);
        @(negedge clk_i);
      end
      in_burst = ($urandom_range(0, 3) == 0);
      kind = pick_kind();
      case (kind)
        FR_GOOD:      run_frame(pick_len(), 2'b00, 1'b1, 1'b1, $urandom_range(0, 3), 0);
        FR_BAD_CRC:   run_frame(pick_len(), 2'b00, 1'b1, 1'b0, $urandom_range(0, 3), 0);
        FR_BAD_TAG:   run_frame(pick_len(), 2'b00, 1'b0, 1'b1, $urandom_range(0, 3), 0);
        FR_TRUNC: begin
          len = pick_len();
          run_frame(len, 2'b00, 1'b1, 1'b1, 0, $urandom_range(1, len + 5));
        end
        FR_BAD_SYNC: begin
          run_frame(pick_len(), 2'($urandom_range(1, 3)), 1'b1, 1'b1, 0,
                    $urandom_range(6, 12));
        end
        FR_BAD_LEN: begin
          len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_PAYLOAD_BYTES + 1, 65535);
          run_frame(len, 2'b00, 1'b1, 1'b1, $urandom_range(0, 4), 0);
        end
        FR_SHORT_LEN: begin
          run_frame($urandom_range(1, RECORD_BYTES - 1), 2'b00, 1'($urandom), 1'b1,
                    $urandom_range(0, 3), 0);
        end
        default: begin
          n = $urandom_range(1, 20);
          for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), i == n - 1 || $urandom_range(0, 5) == 0);
          end
        end
      endcase
      frame_no++;
    end

    in_valid_i = 1'b0;
    wait (results_due == 0);
    @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
